### hw/rtl/j3d_pkg.sv
`timescale 1ns / 1ps

package j3d_pkg;

    localparam int VAL_W = 48;
    localparam int CHG_W = 47;
    localparam int ACC_W = 128;
    localparam int SRC_W = 80;
    localparam int OPR_W = 33;
    localparam int PROD_W = 2 * OPR_W;
    localparam int NUM_OPS = 11;
    localparam int OP_IDX_W = 4;
    localparam int SHIFT_W = 7;

    localparam logic [CHG_W-1:0] CHG_MAX = {CHG_W{1'b1}};

    // Configuration register indexes
    localparam logic [2:0] REG_ROW_LENGTH     = 3'd0;
    localparam logic [2:0] REG_ROWS_PER_PLANE = 3'd1;
    localparam logic [2:0] REG_COEF_X         = 3'd2;
    localparam logic [2:0] REG_COEF_Y         = 3'd3;
    localparam logic [2:0] REG_COEF_Z         = 3'd4;
    localparam logic [2:0] REG_GAIN_A         = 3'd5;
    localparam logic [2:0] REG_SOURCE_SCALE   = 3'd6;
    localparam logic [2:0] REG_SOURCE_CONST   = 3'd7;

    localparam logic [7:0]  RST_ROW_LENGTH     = 8'd128;
    localparam logic [7:0]  RST_ROWS_PER_PLANE = 8'd128;
    localparam logic [19:0] RST_GAIN_A         = 20'd100000;
    localparam logic [31:0] RST_SOURCE_SCALE   = 32'd65536;
    localparam logic [47:0] RST_SOURCE_CONST   = 48'd1610612736;

    // Last MAC op of the source-term phase; the partial sum is snapped there
    localparam logic [OP_IDX_W-1:0] OP_SRC_DONE = 4'd1;
    localparam logic [OP_IDX_W-1:0] OP_LAST = OP_IDX_W'(NUM_OPS - 1);

    typedef struct packed {
        logic signed [VAL_W-1:0] grid_value;
        logic                    last_in;
    } in_item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] new_value;
        logic [CHG_W-1:0]        abs_change;
        logic [CHG_W-1:0]        max_change;
        logic                    last_out;
    } out_item_t;

    typedef struct packed {
        logic [31:0] coef_x;
        logic [31:0] coef_y;
        logic [31:0] coef_z;
        logic [19:0] gain_a;
        logic [31:0] source_scale;
        logic signed [VAL_W-1:0] source_const;
    } arith_cfg_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_WRITE,
        B_READ,
        B_RWAIT,
        B_SUM,
        B_MUL,
        B_ACC,
        B_SAT,
        B_DIFF,
        B_OUT
    } back_state_t;

    typedef enum logic [2:0] {
        RD_WEST,
        RD_EAST,
        RD_SOUTH,
        RD_NORTH,
        RD_CENTER,
        RD_NEXT
    } rd_tag_t;

    typedef enum logic [3:0] {
        CH_C_LO, CH_C_HI,
        CH_S_LO, CH_S_MID, CH_S_HI,
        CH_X_LO, CH_X_HI,
        CH_Y_LO, CH_Y_HI,
        CH_Z_LO, CH_Z_HI
    } chunk_sel_t;

    typedef enum logic [2:0] {
        M_GAIN, M_SCALE, M_CX, M_CY, M_CZ
    } mult_sel_t;

    typedef struct packed {
        chunk_sel_t         chunk;
        mult_sel_t          mult;
        logic [SHIFT_W-1:0] shift;
        logic               sub;
    } mac_op_t;

    // Schedule of the shared multiply-accumulate unit
    function automatic mac_op_t get_op(input logic [OP_IDX_W-1:0] idx);
        mac_op_t op;
        begin
            op = '{CH_C_LO, M_GAIN, 7'd0, 1'b1};
            case (idx)
                4'd0:    op = '{CH_C_LO,  M_GAIN,  7'd0,  1'b1};
                4'd1:    op = '{CH_C_HI,  M_GAIN,  7'd32, 1'b1};
                4'd2:    op = '{CH_S_LO,  M_SCALE, 7'd16, 1'b1};
                4'd3:    op = '{CH_S_MID, M_SCALE, 7'd48, 1'b1};
                4'd4:    op = '{CH_S_HI,  M_SCALE, 7'd80, 1'b1};
                4'd5:    op = '{CH_X_LO,  M_CX,    7'd0,  1'b0};
                4'd6:    op = '{CH_X_HI,  M_CX,    7'd32, 1'b0};
                4'd7:    op = '{CH_Y_LO,  M_CY,    7'd0,  1'b0};
                4'd8:    op = '{CH_Y_HI,  M_CY,    7'd32, 1'b0};
                4'd9:    op = '{CH_Z_LO,  M_CZ,    7'd0,  1'b0};
                4'd10:   op = '{CH_Z_HI,  M_CZ,    7'd32, 1'b0};
                default: op = '{CH_C_LO,  M_GAIN,  7'd0,  1'b1};
            endcase
            return op;
        end
    endfunction

endpackage

### hw/rtl/j3d_fifo.sv
`timescale 1ns / 1ps

module j3d_fifo #(
    parameter int W = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic         empty,
    output logic [W-1:0] head
);

    logic [W-1:0] slot0_reg, slot0_next;
    logic [W-1:0] slot1_reg, slot1_next;
    logic [1:0]   count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = slot0_reg;

    always_comb begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = count_reg;
        if (pop && !empty) begin
            slot0_next = slot1_reg;
            count_next = count_next - 2'd1;
        end
        if (push && !full) begin
            if (count_next == 2'd0) begin
                slot0_next = push_data;
            end else begin
                slot1_next = push_data;
            end
            count_next = count_next + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule

### hw/rtl/j3d_front.sv
`timescale 1ns / 1ps

module j3d_front #(
    parameter int MAX_ROW  = 128,
    parameter int MAX_ROWS = 128,
    parameter int AW       = 15
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              take,
    input  logic              last_in,
    input  logic [7:0]        row_length,
    input  logic [7:0]        rows_per_plane,
    output logic              interior,
    output logic [AW-1:0]     cur_addr,
    output logic [AW-1:0]     prev_addr
);

    localparam int CW    = (MAX_ROW  > 1) ? $clog2(MAX_ROW)  : 1;
    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int MW    = (CW > RW) ? CW : RW;
    localparam int LEN_W = ((MW + 1 > 8) ? MW + 1 : 8) + 1;
    localparam int PLANE = MAX_ROW * MAX_ROWS;

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [1:0]    planes_reg, planes_next;
    logic          bank_reg, bank_next;

    logic [LEN_W-1:0] rl, rp, col_w, row_w;
    logic [AW-1:0]    p;

    always_comb begin
        rl = LEN_W'(row_length);
        if (rl < LEN_W'(3)) begin
            rl = LEN_W'(3);
        end else if (rl > LEN_W'(MAX_ROW)) begin
            rl = LEN_W'(MAX_ROW);
        end
        rp = LEN_W'(rows_per_plane);
        if (rp < LEN_W'(3)) begin
            rp = LEN_W'(3);
        end else if (rp > LEN_W'(MAX_ROWS)) begin
            rp = LEN_W'(MAX_ROWS);
        end
    end

    assign col_w = LEN_W'(col_reg);
    assign row_w = LEN_W'(row_reg);
    assign p = AW'(row_reg) * AW'(MAX_ROW) + AW'(col_reg);

    assign interior = (planes_reg == 2'd2) && (col_reg != '0) && (col_w + LEN_W'(2) <= rl)
                   && (row_reg != '0) && (row_w + LEN_W'(2) <= rp);
    assign cur_addr  = bank_reg ? p + AW'(PLANE) : p;
    assign prev_addr = bank_reg ? p : p + AW'(PLANE);

    always_comb begin
        col_next    = col_reg;
        row_next    = row_reg;
        planes_next = planes_reg;
        bank_next   = bank_reg;
        if (take) begin
            if (last_in) begin
                col_next    = '0;
                row_next    = '0;
                planes_next = 2'd0;
                bank_next   = 1'b0;
            end else if (col_w + LEN_W'(1) >= rl) begin
                col_next = '0;
                if (row_w + LEN_W'(1) >= rp) begin
                    row_next  = '0;
                    bank_next = ~bank_reg;
                    if (planes_reg != 2'd2) begin
                        planes_next = planes_reg + 2'd1;
                    end
                end else begin
                    row_next = row_reg + RW'(1);
                end
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg    <= '0;
            row_reg    <= '0;
            planes_reg <= 2'd0;
            bank_reg   <= 1'b0;
        end else begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            planes_reg <= planes_next;
            bank_reg   <= bank_next;
        end
    end

endmodule

### hw/rtl/j3d_back.sv
`timescale 1ns / 1ps

module j3d_back #(
    parameter int MAX_ROW  = 128,
    parameter int MAX_ROWS = 128,
    parameter int AW       = 15
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  j3d_pkg::arith_cfg_t  cfg,
    input  logic                 job_avail,
    input  logic                 job_interior,
    input  logic [AW-1:0]        job_cur,
    input  logic [AW-1:0]        job_prev,
    input  j3d_pkg::in_item_t    job_item,
    output logic                 job_pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output j3d_pkg::out_item_t   m_item
);

    localparam int DEPTH = 2 * MAX_ROW * MAX_ROWS;
    localparam int VW = j3d_pkg::VAL_W;

    j3d_pkg::back_state_t state_reg, state_next;

    logic signed [VW-1:0] mem [DEPTH];
    logic signed [VW-1:0] rd_data_reg;
    logic                 rd_pend_reg;
    j3d_pkg::rd_tag_t     rd_tag_reg, rd_idx_reg, rd_idx_next;

    logic                 job_int_reg, job_last_reg;
    logic [AW-1:0]        job_cur_reg, job_prev_reg;
    logic signed [VW-1:0] job_val_reg;

    logic signed [VW-1:0] w_reg, e_reg, s_reg, n_reg, c_reg, nx_reg;
    logic signed [VW:0]   we_reg, ns_reg, bt_reg;

    logic [j3d_pkg::OP_IDX_W-1:0]     op_idx_reg, op_idx_next;
    logic signed [j3d_pkg::PROD_W-1:0] prod_reg;
    logic signed [j3d_pkg::ACC_W-1:0]  acc_reg, acc_sum;
    logic signed [j3d_pkg::SRC_W-1:0]  src_reg;
    logic signed [VW-1:0]              nv_reg;
    logic [j3d_pkg::CHG_W-1:0]         ad_reg, run_max_reg, new_max;
    logic                              m_valid_reg;
    j3d_pkg::out_item_t                m_item_reg;

    logic                 mem_we;
    logic [AW-1:0]        raddr;
    logic                 out_free, out_load;
    j3d_pkg::mac_op_t     op;
    logic signed [j3d_pkg::OPR_W-1:0] chunk, mult;
    logic signed [j3d_pkg::ACC_W-1:0] prod_sh;
    logic signed [VW:0]   diff;
    logic [VW:0]          diff_abs;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;
    assign op       = j3d_pkg::get_op(op_idx_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            j3d_pkg::B_IDLE:  if (job_avail) begin
                state_next = job_interior ? j3d_pkg::B_READ : j3d_pkg::B_WRITE;
            end
            j3d_pkg::B_WRITE: state_next = job_last_reg ? j3d_pkg::B_OUT : j3d_pkg::B_IDLE;
            j3d_pkg::B_READ:  if (rd_idx_reg == j3d_pkg::RD_NEXT) begin
                state_next = j3d_pkg::B_RWAIT;
            end
            j3d_pkg::B_RWAIT: state_next = j3d_pkg::B_SUM;
            j3d_pkg::B_SUM:   state_next = j3d_pkg::B_MUL;
            j3d_pkg::B_MUL:   state_next = j3d_pkg::B_ACC;
            j3d_pkg::B_ACC:   state_next = (op_idx_reg == j3d_pkg::OP_LAST) ?
                                           j3d_pkg::B_SAT : j3d_pkg::B_MUL;
            j3d_pkg::B_SAT:   state_next = j3d_pkg::B_DIFF;
            j3d_pkg::B_DIFF:  state_next = j3d_pkg::B_OUT;
            j3d_pkg::B_OUT:   if (out_free) begin
                state_next = j3d_pkg::B_IDLE;
            end
            default:          state_next = j3d_pkg::B_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        job_pop     = 1'b0;
        mem_we      = 1'b0;
        out_load    = 1'b0;
        rd_idx_next = rd_idx_reg;
        op_idx_next = op_idx_reg;
        case (state_reg)
            j3d_pkg::B_IDLE: begin
                job_pop     = job_avail;
                rd_idx_next = j3d_pkg::RD_WEST;
            end
            j3d_pkg::B_WRITE: mem_we = 1'b1;
            j3d_pkg::B_READ:  rd_idx_next = j3d_pkg::rd_tag_t'(rd_idx_reg + 3'd1);
            j3d_pkg::B_SUM: begin
                mem_we      = 1'b1;
                op_idx_next = '0;
            end
            j3d_pkg::B_ACC:   op_idx_next = op_idx_reg + j3d_pkg::OP_IDX_W'(1);
            j3d_pkg::B_OUT:   out_load = out_free;
            default: begin
            end
        endcase
    end

    always_comb begin
        case (rd_idx_reg)
            j3d_pkg::RD_WEST:   raddr = job_prev_reg - AW'(1);
            j3d_pkg::RD_EAST:   raddr = job_prev_reg + AW'(1);
            j3d_pkg::RD_SOUTH:  raddr = job_prev_reg - AW'(MAX_ROW);
            j3d_pkg::RD_NORTH:  raddr = job_prev_reg + AW'(MAX_ROW);
            j3d_pkg::RD_CENTER: raddr = job_prev_reg;
            j3d_pkg::RD_NEXT:   raddr = job_cur_reg;
            default:            raddr = job_cur_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[job_cur_reg] <= job_val_reg;
        end
        rd_data_reg <= mem[raddr];
    end

    // operand selection for the shared multiplier; upper chunks carry the sign
    always_comb begin
        case (op.chunk)
            j3d_pkg::CH_C_LO:  chunk = {1'b0, c_reg[31:0]};
            j3d_pkg::CH_C_HI:  chunk = j3d_pkg::OPR_W'($signed(c_reg[VW-1:32]));
            j3d_pkg::CH_S_LO:  chunk = {1'b0, src_reg[31:0]};
            j3d_pkg::CH_S_MID: chunk = {1'b0, src_reg[63:32]};
            j3d_pkg::CH_S_HI:  chunk = j3d_pkg::OPR_W'($signed(src_reg[j3d_pkg::SRC_W-1:64]));
            j3d_pkg::CH_X_LO:  chunk = {1'b0, we_reg[31:0]};
            j3d_pkg::CH_X_HI:  chunk = j3d_pkg::OPR_W'($signed(we_reg[VW:32]));
            j3d_pkg::CH_Y_LO:  chunk = {1'b0, ns_reg[31:0]};
            j3d_pkg::CH_Y_HI:  chunk = j3d_pkg::OPR_W'($signed(ns_reg[VW:32]));
            j3d_pkg::CH_Z_LO:  chunk = {1'b0, bt_reg[31:0]};
            j3d_pkg::CH_Z_HI:  chunk = j3d_pkg::OPR_W'($signed(bt_reg[VW:32]));
            default:           chunk = '0;
        endcase
        case (op.mult)
            j3d_pkg::M_GAIN:  mult = {13'd0, cfg.gain_a};
            j3d_pkg::M_SCALE: mult = {1'b0, cfg.source_scale};
            j3d_pkg::M_CX:    mult = {1'b0, cfg.coef_x};
            j3d_pkg::M_CY:    mult = {1'b0, cfg.coef_y};
            j3d_pkg::M_CZ:    mult = {1'b0, cfg.coef_z};
            default:          mult = '0;
        endcase
    end

    assign prod_sh = j3d_pkg::ACC_W'(prod_reg) <<< op.shift;
    assign acc_sum = op.sub ? acc_reg - prod_sh : acc_reg + prod_sh;
    assign diff = j3d_pkg::VAL_W'(0) + (VW+1)'(nv_reg) - (VW+1)'(c_reg);
    assign diff_abs = diff[VW] ? (VW+1)'(-diff) : (VW+1)'(diff);
    assign new_max = (job_int_reg && ad_reg > run_max_reg) ? ad_reg : run_max_reg;

    always_ff @(posedge aclk) begin
        rd_pend_reg <= (state_reg == j3d_pkg::B_READ);
        rd_tag_reg  <= rd_idx_reg;
        if (rd_pend_reg) begin
            case (rd_tag_reg)
                j3d_pkg::RD_WEST:   w_reg  <= rd_data_reg;
                j3d_pkg::RD_EAST:   e_reg  <= rd_data_reg;
                j3d_pkg::RD_SOUTH:  s_reg  <= rd_data_reg;
                j3d_pkg::RD_NORTH:  n_reg  <= rd_data_reg;
                j3d_pkg::RD_CENTER: c_reg  <= rd_data_reg;
                j3d_pkg::RD_NEXT:   nx_reg <= rd_data_reg;
                default: begin
                end
            endcase
        end
        if (job_pop) begin
            job_int_reg  <= job_interior;
            job_last_reg <= job_item.last_in;
            job_cur_reg  <= job_cur;
            job_prev_reg <= job_prev;
            job_val_reg  <= job_item.grid_value;
        end
        if (state_reg == j3d_pkg::B_SUM) begin
            we_reg  <= (VW+1)'(w_reg) + (VW+1)'(e_reg);
            ns_reg  <= (VW+1)'(s_reg) + (VW+1)'(n_reg);
            bt_reg  <= (VW+1)'(nx_reg) + (VW+1)'(job_val_reg);
            acc_reg <= j3d_pkg::ACC_W'(cfg.source_const);
        end
        if (state_reg == j3d_pkg::B_MUL) begin
            prod_reg <= chunk * mult;
        end
        if (state_reg == j3d_pkg::B_ACC) begin
            if (op_idx_reg == j3d_pkg::OP_SRC_DONE) begin
                src_reg <= acc_sum[j3d_pkg::SRC_W-1:0];
                acc_reg <= '0;
            end else begin
                acc_reg <= acc_sum;
            end
        end
        if (state_reg == j3d_pkg::B_SAT) begin
            // floor shift by 32 then clamp to the 48-bit range
            if (acc_reg[j3d_pkg::ACC_W-1:79] == '0 || acc_reg[j3d_pkg::ACC_W-1:79] == '1) begin
                nv_reg <= acc_reg[79:32];
            end else if (acc_reg[j3d_pkg::ACC_W-1]) begin
                nv_reg <= {1'b1, {(VW-1){1'b0}}};
            end else begin
                nv_reg <= {1'b0, {(VW-1){1'b1}}};
            end
        end
        if (state_reg == j3d_pkg::B_DIFF) begin
            ad_reg <= (diff_abs > (VW+1)'(j3d_pkg::CHG_MAX)) ? j3d_pkg::CHG_MAX :
                      diff_abs[j3d_pkg::CHG_W-1:0];
        end
        if (out_load) begin
            m_item_reg.new_value  <= job_int_reg ? nv_reg : '0;
            m_item_reg.abs_change <= job_int_reg ? ad_reg : '0;
            m_item_reg.max_change <= new_max;
            m_item_reg.last_out   <= job_last_reg;
        end
        if (!aresetn) begin
            state_reg   <= j3d_pkg::B_IDLE;
            rd_idx_reg  <= j3d_pkg::RD_WEST;
            op_idx_reg  <= '0;
            run_max_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            rd_idx_reg <= rd_idx_next;
            op_idx_reg <= op_idx_next;
            if (out_load) begin
                run_max_reg <= job_last_reg ? '0 : new_max;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

### hw/rtl/jacobi_3d_seven_point_stencil.sv
`timescale 1ns / 1ps
// Streaming 3D Jacobi seven-point stencil over a haloed block.
// Input channel (s_valid/s_ready/s_item): grid values in raster order, column
// fastest, then row, then plane; last_in marks the final point of a block.
// Result channel (m_valid/m_ready/m_item): one updated interior point per
// interior center once its upper neighbour plane arrives, with |change| and
// the running maximum change; last_in always yields one item with last_out
// set (a closing item with zero value and change if the point was not interior).
// Configuration: cfg_we writes cfg_data into register cfg_index at once;
// write only while the block is idle.
// Back end, one point at a time: a halo point is written to the plane store;
// an interior point takes six reads of the plane store, then eleven steps of
// one shared 33x33 multiply-accumulate, then saturation.
// A two-entry queue sits between classification and the back end, so s_ready
// stays high while a result waits in the output register until the queue fills.
// Reset (aresetn low, synchronous) clears positions, plane count and the
// running maximum; the plane store is not cleared and is filled by the first
// two planes of each block. A stalled receiver holds the output register and,
// once the queue fills, drops s_ready.
module jacobi_3d_seven_point_stencil #(
    parameter int MAX_ROW  = 128,
    parameter int MAX_ROWS = 128
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  j3d_pkg::in_item_t   s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output j3d_pkg::out_item_t  m_item,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [47:0]         cfg_data
);

    localparam int AW = $clog2(2 * MAX_ROW * MAX_ROWS);
    localparam int IW = $bits(j3d_pkg::in_item_t);
    localparam int EW = 1 + 2 * AW + IW;

    logic [7:0]          row_length_reg, rows_per_plane_reg;
    j3d_pkg::arith_cfg_t cfg_reg;

    logic          take, fifo_full, fifo_empty, pop;
    logic          f_interior;
    logic [AW-1:0] f_cur, f_prev;
    logic [EW-1:0] push_data, head;

    // Configuration registers; writes land immediately
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_length_reg       <= j3d_pkg::RST_ROW_LENGTH;
            rows_per_plane_reg   <= j3d_pkg::RST_ROWS_PER_PLANE;
            cfg_reg.coef_x       <= '0;
            cfg_reg.coef_y       <= '0;
            cfg_reg.coef_z       <= '0;
            cfg_reg.gain_a       <= j3d_pkg::RST_GAIN_A;
            cfg_reg.source_scale <= j3d_pkg::RST_SOURCE_SCALE;
            cfg_reg.source_const <= j3d_pkg::RST_SOURCE_CONST;
        end else if (cfg_we) begin
            case (cfg_index)
                j3d_pkg::REG_ROW_LENGTH:     row_length_reg       <= cfg_data[7:0];
                j3d_pkg::REG_ROWS_PER_PLANE: rows_per_plane_reg   <= cfg_data[7:0];
                j3d_pkg::REG_COEF_X:         cfg_reg.coef_x       <= cfg_data[31:0];
                j3d_pkg::REG_COEF_Y:         cfg_reg.coef_y       <= cfg_data[31:0];
                j3d_pkg::REG_COEF_Z:         cfg_reg.coef_z       <= cfg_data[31:0];
                j3d_pkg::REG_GAIN_A:         cfg_reg.gain_a       <= cfg_data[19:0];
                j3d_pkg::REG_SOURCE_SCALE:   cfg_reg.source_scale <= cfg_data[31:0];
                j3d_pkg::REG_SOURCE_CONST:   cfg_reg.source_const <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Accept whenever the queue has room
    assign s_ready = !fifo_full;
    assign take    = s_valid && s_ready;

    // Classify each item and track its place in the block
    j3d_front #(
        .MAX_ROW  (MAX_ROW),
        .MAX_ROWS (MAX_ROWS),
        .AW       (AW)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .take           (take),
        .last_in        (s_item.last_in),
        .row_length     (row_length_reg),
        .rows_per_plane (rows_per_plane_reg),
        .interior       (f_interior),
        .cur_addr       (f_cur),
        .prev_addr      (f_prev)
    );

    assign push_data = {f_interior, f_cur, f_prev, s_item};

    // Hold classified items until the back end is free
    j3d_fifo #(
        .W (EW)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (take),
        .push_data (push_data),
        .full      (fifo_full),
        .pop       (pop),
        .empty     (fifo_empty),
        .head      (head)
    );

    // Plane store, shared multiply-accumulate and output register
    j3d_back #(
        .MAX_ROW  (MAX_ROW),
        .MAX_ROWS (MAX_ROWS),
        .AW       (AW)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .job_avail    (!fifo_empty),
        .job_interior (head[EW-1]),
        .job_cur      (head[EW-2 -: AW]),
        .job_prev     (head[EW-2-AW -: AW]),
        .job_item     (head[IW-1:0]),
        .job_pop      (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_item       (m_item)
    );

endmodule
